/* design/csc_pkg.sv */
// Types, codes and helper functions shared by the color sensor classifier.
`default_nettype none
package csc_pkg;

   localparam int CountW   = 16;
   localparam int TickW    = 24;
   localparam int ReadW    = 24;
   localparam int SumW     = 28;
   localparam int ScaleW   = 8;
   localparam int TolW     = 16;
   localparam int RoundW   = 4;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 24;
   localparam int RspDataW = 80;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_SETTLE = 4'b0010,
      PH_GATE   = 4'b0100,
      PH_DRAIN  = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_MEASURE = 2'd1,
      CMD_CAL     = 2'd2,
      CMD_SPARE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CLASS_NONE  = 2'd0,
      CLASS_RED   = 2'd1,
      CLASS_GREEN = 2'd2,
      CLASS_BLUE  = 2'd3
   } class_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_SETTLE    = 2'd0,
      CSR_GATE      = 2'd1,
      CSR_SCALE     = 2'd2,
      CSR_TOLERANCE = 2'd3
   } csr_index_type;

   localparam logic [1:0] SLOT_RED   = 2'd0;
   localparam logic [1:0] SLOT_GREEN = 2'd1;
   localparam logic [1:0] SLOT_BLUE  = 2'd2;

   localparam logic [1:0] CHAN_LAST = 2'd2;

   typedef logic [ReadW-1:0] reading_type [3];
   typedef logic [SumW-1:0]  sum_type [3];

   // Filters are visited red, blue, green.
   function automatic logic [1:0] chan_slot(input logic [1:0] chan);
      logic [1:0] slot;
      case (chan)
         2'd0:    slot = SLOT_RED;
         2'd1:    slot = SLOT_BLUE;
         2'd2:    slot = SLOT_GREEN;
         default: slot = SLOT_RED;
      endcase
      return slot;
   endfunction

   // Returns the select pair {s3, s2} for a channel step.
   function automatic logic [1:0] chan_selects(input logic [1:0] chan);
      logic [1:0] sel;
      case (chan)
         2'd0:    sel = 2'b00;
         2'd1:    sel = 2'b10;
         2'd2:    sel = 2'b11;
         default: sel = 2'b00;
      endcase
      return sel;
   endfunction

endpackage
`default_nettype wire

/* design/color_sensor_classifier.sv */
// Top level of the color sensor classifier: run sequencer, pulse counter and classifier.
//
//   Channel  Ports                       Item
//   -------  --------------------------  ---------------------------------------------
//   input    req_tvalid/tready/tdata/    one sensor sample, optionally a start command
//            tuser
//   result   rsp_tvalid/tready/tdata     selects, status flags, class, three readings
//   config   csr_valid/ready/index/data  one register write
//
// Every accepted item produces one registered result item, and a new item can be
// accepted in every cycle. The result register is refilled in the same cycle it is taken,
// so the input stalls only while an untaken result waits. Baselines are written in the
// cycle after a calibration completes. Reset clears all run state, the readings and the
// baselines, and loads the default register values.
`default_nettype none
module color_sensor_classifier
   import csc_pkg::*;
#(
   parameter int CAL_ROUNDS = 10
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [7:0]          req_tdata,   // [0] sensor_level
   input  wire logic [1:0]          req_tuser,   // [1:0] cmd
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [RspDataW-1:0]      rsp_tdata,   // [0] filter_s2, [1] filter_s3,
                                                 // [2] busy_res, [3] color_valid,
                                                 // [4] calibration_done,
                                                 // [6:5] color_class,
                                                 // [30:7] red_reading,
                                                 // [54:31] green_reading,
                                                 // [78:55] blue_reading
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [CsrDataW-1:0] csr_data
);

   localparam int DivShift = SumW + $clog2(CAL_ROUNDS);
   localparam logic [63:0] DivMult64 =
      ((64'd1 << DivShift) + 64'(CAL_ROUNDS) - 64'd1) / 64'(CAL_ROUNDS);
   localparam logic [SumW:0] DivMult = DivMult64[SumW:0];
   localparam int ProdW = 2 * SumW + 1;

   logic [TickW-1:0]  settle_ff, gate_ff;
   logic [ScaleW-1:0] scale_ff;
   logic [TolW-1:0]   tol_ff;

   phase_type         phase_ff, phase_in;
   logic              cal_ff, cal_in;
   logic [1:0]        chan_ff, chan_in;
   logic [TickW-1:0]  tick_ff, tick_in;
   logic [CountW-1:0] cnt_ff, cnt_in;
   logic [ReadW-1:0]  scaled_ff, scaled_in;
   logic              high_ff, high_in;
   logic [RoundW-1:0] round_ff, round_in;
   sum_type           sums_ff, sums_in;
   reading_type       base_ff;
   reading_type       read_ff, read_in;
   logic              div_pend_ff, div_pend_in;

   logic              rsp_valid_ff;
   logic [RspDataW-1:0] rsp_data_ff, rsp_data_in;

   logic              accept;
   cmd_type           cmd;
   logic              lvl;
   logic              valid_o, done_o;
   class_type         cls_o;
   logic [1:0]        sel;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign cmd        = cmd_type'(req_tuser);
   assign lvl        = req_tdata[0];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= TickW'(50000);
         gate_ff   <= TickW'(100000);
         scale_ff  <= ScaleW'(10);
         tol_ff    <= TolW'(30);
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_SETTLE:    settle_ff <= csr_data;
            CSR_GATE:      gate_ff   <= csr_data;
            CSR_SCALE:     scale_ff  <= csr_data[ScaleW-1:0];
            CSR_TOLERANCE: tol_ff    <= csr_data[TolW-1:0];
            default:       settle_ff <= settle_ff;
         endcase
      end
   end

   always_comb begin
      logic              gate_now;
      logic [TickW-1:0]  tick_b;
      logic [CountW-1:0] cnt_b;
      logic [ReadW-1:0]  scaled_b;
      logic              high_b;
      logic              do_count;
      logic              finish;
      logic [1:0]        slot;
      logic [ReadW-1:0]  value;
      logic [RoundW-1:0] round_nx;
      logic [ReadW:0]    thr [3];
      logic              below;
      logic [ReadW-1:0]  r, g, b;

      phase_in    = phase_ff;
      cal_in      = cal_ff;
      chan_in     = chan_ff;
      tick_in     = tick_ff;
      cnt_in      = cnt_ff;
      scaled_in   = scaled_ff;
      high_in     = high_ff;
      round_in    = round_ff;
      sums_in     = sums_ff;
      read_in     = read_ff;
      div_pend_in = 1'b0;
      valid_o     = 1'b0;
      done_o      = 1'b0;
      cls_o       = CLASS_NONE;
      gate_now    = 1'b0;
      tick_b      = tick_ff;
      cnt_b       = cnt_ff;
      scaled_b    = scaled_ff;
      high_b      = high_ff;
      do_count    = 1'b0;
      finish      = 1'b0;
      round_nx    = round_ff + RoundW'(1);

      case (phase_ff)
         PH_IDLE: begin
            if (cmd == CMD_MEASURE || cmd == CMD_CAL) begin
               cal_in   = (cmd == CMD_CAL);
               chan_in  = 2'd0;
               round_in = '0;
               for (int i = 0; i < 3; i++) sums_in[i] = '0;
               phase_in = PH_SETTLE;
               tick_in  = '0;
            end
         end
         PH_SETTLE: begin
            if (tick_ff >= settle_ff) begin
               gate_now = 1'b1;
               tick_b   = '0;
               cnt_b    = '0;
               scaled_b = '0;
               high_b   = 1'b0;
               phase_in = PH_GATE;
            end else begin
               tick_in = tick_ff + TickW'(1);
            end
         end
         PH_GATE: begin
            gate_now = 1'b1;
         end
         PH_DRAIN: begin
            if (!lvl) begin
               do_count = 1'b1;
               finish   = 1'b1;
            end
         end
         default: phase_in = PH_IDLE;
      endcase

      if (gate_now) begin
         if (lvl) begin
            high_b = 1'b1;
         end else if (high_b) begin
            do_count = 1'b1;
         end
         tick_in = tick_b + TickW'(1);
         high_in = high_b;
         if (tick_in >= gate_ff || tick_in == '0) begin
            if (high_b && !do_count) begin
               phase_in = PH_DRAIN;
            end else begin
               finish = 1'b1;
            end
         end
      end

      if (gate_now || do_count) begin
         cnt_in    = cnt_b;
         scaled_in = scaled_b;
      end
      if (do_count) begin
         high_in = 1'b0;
         if (cnt_b != '1) begin
            cnt_in    = cnt_b + CountW'(1);
            scaled_in = scaled_b + ReadW'(scale_ff);
         end
      end

      slot  = chan_slot(chan_ff);
      value = scaled_in;
      if (finish) begin
         read_in[slot] = value;
         if (cal_ff) sums_in[slot] = sums_ff[slot] + SumW'(value);
         high_in = 1'b0;
         if (chan_ff != CHAN_LAST) begin
            chan_in  = chan_ff + 2'd1;
            phase_in = PH_SETTLE;
            tick_in  = '0;
         end else begin
            chan_in = 2'd0;
            if (cal_ff) begin
               if (round_nx >= RoundW'(CAL_ROUNDS)) begin
                  done_o      = 1'b1;
                  div_pend_in = 1'b1;
                  phase_in    = PH_IDLE;
                  round_in    = '0;
               end else begin
                  round_in = round_nx;
                  phase_in = PH_SETTLE;
                  tick_in  = '0;
               end
            end else begin
               valid_o  = 1'b1;
               phase_in = PH_IDLE;
            end
         end
      end

      for (int i = 0; i < 3; i++) thr[i] = {1'b0, base_ff[i]} + (ReadW + 1)'(tol_ff);
      r = read_in[SLOT_RED];
      g = read_in[SLOT_GREEN];
      b = read_in[SLOT_BLUE];
      below = ({1'b0, r} < thr[SLOT_RED]) && ({1'b0, g} < thr[SLOT_GREEN]) &&
              ({1'b0, b} < thr[SLOT_BLUE]);
      if (valid_o) begin
         if (below) begin
            cls_o = CLASS_NONE;
         end else if (r > g && r > b) begin
            cls_o = CLASS_RED;
         end else if (g > r && g > b) begin
            cls_o = CLASS_GREEN;
         end else begin
            cls_o = CLASS_BLUE;
         end
      end
   end

   assign sel = chan_selects(chan_in);
   assign rsp_data_in = {1'b0, read_in[SLOT_BLUE], read_in[SLOT_GREEN], read_in[SLOT_RED],
                         cls_o, done_o, valid_o, phase_in != PH_IDLE, sel[1], sel[0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         cal_ff      <= 1'b0;
         chan_ff     <= 2'd0;
         tick_ff     <= '0;
         cnt_ff      <= '0;
         scaled_ff   <= '0;
         high_ff     <= 1'b0;
         round_ff    <= '0;
         div_pend_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            sums_ff[i] <= '0;
            read_ff[i] <= '0;
         end
      end else begin
         div_pend_ff <= accept && div_pend_in;
         if (accept) begin
            phase_ff  <= phase_in;
            cal_ff    <= cal_in;
            chan_ff   <= chan_in;
            tick_ff   <= tick_in;
            cnt_ff    <= cnt_in;
            scaled_ff <= scaled_in;
            high_ff   <= high_in;
            round_ff  <= round_in;
            sums_ff   <= sums_in;
            read_ff   <= read_in;
         end
      end
   end

   // Division of the final sums by the round count, done as a reciprocal multiply.
   always_ff @(posedge clock) begin
      logic [ProdW-1:0] prod;
      if (reset) begin
         for (int i = 0; i < 3; i++) base_ff[i] <= '0;
      end else if (div_pend_ff) begin
         for (int i = 0; i < 3; i++) begin
            prod       = ProdW'(sums_ff[i]) * ProdW'(DivMult);
            base_ff[i] <= prod[DivShift +: ReadW];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire
